>>> rtl/urfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// urfr_pkg
// Types and constants for the UART receive FIFO with RTS flow control.
// ----------------------------------------------------------------------------
package urfr_pkg;

  // Operation codes carried by a command transfer
  typedef enum logic [1:0] {
    FUNC_RECV   = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_FLUSH  = 2'd2,
    FUNC_CANCEL = 2'd3
  } func_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_HIGH_WATER = 2'd0;
  localparam logic [1:0] CFG_LOW_WATER  = 2'd1;

  // Register widths and reset values
  localparam int unsigned WATER_W        = 10;
  localparam int unsigned CNT_OUT_W      = 10;
  localparam logic [9:0]  HIGH_WATER_RST = 10'd768;
  localparam logic [9:0]  LOW_WATER_RST  = 10'd256;

  // Byte left behind by a cancel
  localparam logic [7:0]  CAN_BYTE = 8'h18;

  typedef struct packed {
    func_e      func;
    logic [7:0] rx_byte;
    logic       realtime_taken;
  } cmd_t;

  typedef struct packed {
    logic                 read_valid;
    logic [7:0]           read_byte;
    logic [CNT_OUT_W-1:0] fill_count;
    logic [CNT_OUT_W-1:0] free_count;
    logic                 overflow_flag;
    logic                 rts_level;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/uart_rx_fifo_rts_flow_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uart_rx_fifo_rts_flow_unit
// Receive ring buffer with sticky overflow and RTS hysteresis.
// ----------------------------------------------------------------------------
//  channel   signals                          direction  transfer when
//  command   start_i, busy_o, cmd_i           in         start_i && !busy_o
//  result    done_o, result_o                 out        done_o (one cycle)
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i in         cfg_we_i
//
//  One command is taken every cycle; busy_o stays low.
//  Each result is registered and appears in the cycle after its command
//  transfer; the read of the byte memory is registered as well.
//  Reset clears pointers and flags and loads the watermark defaults; the byte
//  memory has no clearing pass and its data is only reported between the pointers.
//  The receiver cannot stall; the result strobe lasts one cycle.
// ----------------------------------------------------------------------------
module uart_rx_fifo_rts_flow_unit #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  urfr_pkg::cmd_t     cmd_i,
  output logic               done_o,
  output urfr_pkg::res_t     result_o,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [9:0]    cfg_wdata_i
);
  import urfr_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = (AW > WATER_W) ? AW : WATER_W;

  logic [7:0]         byte_mem [DEPTH];
  logic [AW-1:0]      wp_q, wp_d, rp_q, rp_d, wp_inc, rp_inc;
  logic               ovf_q, ovf_d, rts_q, rts_d;
  logic [WATER_W-1:0] hw_q, lw_q;
  logic               done_q, valid_q, valid_d;
  logic [7:0]         rdata_q;
  logic [CNT_OUT_W-1:0] fill_q, free_q;
  logic               accept, full, empty, mem_we;
  logic [7:0]         mem_wdata;
  logic [AW:0]        diff;
  logic [AW-1:0]      cnt_d;
  logic [CW-1:0]      cnt_ext, free_ext;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Pointer increments with wrap at the buffer depth
  assign wp_inc = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rp_inc = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
  assign full   = (wp_inc == rp_q);
  assign empty  = (wp_q == rp_q);

  // Fill count after the operation
  assign diff     = {1'b0, wp_d} - {1'b0, rp_d};
  assign cnt_d    = diff[AW] ? AW'(diff + (AW+1)'(DEPTH)) : diff[AW-1:0];
  assign cnt_ext  = CW'(cnt_d);
  assign free_ext = CW'(DEPTH - 1) - cnt_ext;

  // Apply one operation to the pointers, the overflow flag, the memory write and the read-valid bit
  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    ovf_d     = ovf_q;
    valid_d   = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = cmd_i.rx_byte;
    unique case (cmd_i.func)
      FUNC_RECV: begin
        if (!cmd_i.realtime_taken) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            mem_we = 1'b1;
            wp_d   = wp_inc;
          end
        end
      end
      FUNC_READ: begin
        if (!empty) begin
          valid_d = 1'b1;
          rp_d    = rp_inc;
        end
      end
      FUNC_FLUSH: begin
        rp_d = wp_q;
      end
      FUNC_CANCEL: begin
        mem_we    = 1'b1;
        mem_wdata = CAN_BYTE;
        rp_d      = wp_q;
        wp_d      = wp_inc;
      end
    endcase
  end

  // Raise or drop RTS from the fill count that the operation leaves; flush and cancel always drop it
  always_comb begin
    rts_d = rts_q;
    unique case (cmd_i.func)
      FUNC_RECV: begin
        if (cnt_ext >= CW'(hw_q)) begin
          rts_d = 1'b1;
        end
      end
      FUNC_READ: begin
        if (!empty && (cnt_ext < CW'(lw_q))) begin
          rts_d = 1'b0;
        end
      end
      FUNC_FLUSH: begin
        rts_d = 1'b0;
      end
      FUNC_CANCEL: begin
        rts_d = 1'b0;
      end
    endcase
  end

  // Byte memory: write at the write pointer, registered read at the read pointer
  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      byte_mem[wp_q] <= mem_wdata;
    end
    if (accept && cmd_i.func == FUNC_READ) begin
      rdata_q <= byte_mem[rp_q];
    end
  end

  // Hold the control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      ovf_q   <= 1'b0;
      rts_q   <= 1'b0;
      done_q  <= 1'b0;
      valid_q <= 1'b0;
      hw_q    <= HIGH_WATER_RST;
      lw_q    <= LOW_WATER_RST;
    end else begin
      done_q <= accept;
      if (accept) begin
        wp_q    <= wp_d;
        rp_q    <= rp_d;
        ovf_q   <= ovf_d;
        rts_q   <= rts_d;
        valid_q <= valid_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HIGH_WATER: hw_q <= cfg_wdata_i;
          CFG_LOW_WATER:  lw_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Capture the reported counts
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fill_q <= cnt_ext[CNT_OUT_W-1:0];
      free_q <= free_ext[CNT_OUT_W-1:0];
    end
  end

  // Drive the result
  assign done_o                 = done_q;
  assign result_o.read_valid    = valid_q;
  assign result_o.read_byte     = valid_q ? rdata_q : 8'h00;
  assign result_o.fill_count    = fill_q;
  assign result_o.free_count    = free_q;
  assign result_o.overflow_flag = ovf_q;
  assign result_o.rts_level     = rts_q;

`ifndef SYNTHESIS
  a_done_follows_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("result strobe missing after command transfer");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result strobe without command transfer");

  a_counts_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (CNT_OUT_W'(result_o.fill_count + result_o.free_count)
                == CNT_OUT_W'(DEPTH - 1)))
    else $error("fill and free counts disagree");

  a_valid_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.read_valid) |-> ($past(cmd_i.func) == FUNC_READ))
    else $error("read data reported for a non-read operation");

  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared without reset");

  a_cancel_leaves_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.func == FUNC_CANCEL) |=> (result_o.fill_count == CNT_OUT_W'(1)))
    else $error("cancel did not leave a single byte");
`endif

endmodule
`default_nettype wire
